// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the decompressor unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition holds on the edge after another.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lzbf_pkg.sv -----
// ----------------------------------------------------------------------------
// lzbf_pkg
// Types and constants shared by the bit-flag LZ decompressor modules.
// ----------------------------------------------------------------------------
package lzbf_pkg;

  // Result status codes
  localparam logic [2:0] ST_HDR_OK = 3'd0;
  localparam logic [2:0] ST_DATA   = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_EARLY  = 3'd4;

  localparam logic [7:0] HDR_SUM   = 8'd171;
  localparam logic [2:0] HDR_LAST  = 3'd5;
  localparam int unsigned LONG_SPAN = 8192;

  // Decoder phases
  typedef enum logic [3:0] {
    PH_HDR, PH_TOP, PH_KIND, PH_SC1, PH_SC2, PH_LIT, PH_SOFF,
    PH_LLO, PH_LHI, PH_LCNT, PH_DONE, PH_BAD
  } phase_t;

  // Control FSM of the top level
  typedef enum logic [1:0] {
    CS_IDLE, CS_COPY, CS_EMIT
  } ctl_t;

  // Copy request from the parser to the history engine
  typedef struct packed {
    logic        go;
    logic [16:0] distance;
    logic [8:0]  count;
  } copy_req_t;

endpackage

// ----- rtl/lz_bitflag_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// lz_bitflag_decompressor_unit
// Streaming decompressor for a bit-flag LZ77 format.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall   in_byte
//  output    out        out_valid/out_stall out_data out_count status stream_size last
//
// The input is held off while control bits remain to be consumed after an
// accepted byte (up to four per token).
// A match copies one byte per cycle, unless the output stalls, through the
// registered history memory read port (forwarded when the source is the byte
// just written).
// Reset is synchronous; history is undefined until written.
// An output stall holds the result register, the input and the copy.
module lz_bitflag_decompressor_unit #(
  parameter int unsigned WINDOW_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic [2:0]  status,
  output logic [15:0] stream_size,
  output logic        last
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned PW = AW + 1;

  lzbf_pkg::ctl_t   cs, cs_next;
  lzbf_pkg::phase_t phase, phase_next;

  logic [2:0]  header_index;
  logic [7:0]  header_sum;
  logic [15:0] size_word;
  logic [15:0] bit_queue;
  logic [4:0]  bits_left;
  logic [7:0]  held_byte;
  logic [1:0]  scb;
  logic [AW-1:0] wp;
  logic [PW-1:0] produced;

  // Copy engine
  logic [8:0]  cnt;
  logic [16:0] distance;
  logic        rd_pend;
  logic        rd_early;
  logic [7:0]  fwd_byte;
  logic        fwd_use;
  logic [63:0] acc;
  logic [3:0]  acc_n;
  logic        acc_early;

  logic [7:0]  rdata;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]  mem_wd;
  logic [AW-1:0] mem_ra;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        bits_pend;
  logic [7:0]  hdr_sum_next;
  logic [PW-1:0] produced_inc;
  lzbf_pkg::copy_req_t req;

  // Hold off the input while control bits remain to be consumed
  assign bits_pend = bits_left >= 5'd1 && bits_left <= 5'd16 &&
                     (phase == lzbf_pkg::PH_TOP || phase == lzbf_pkg::PH_KIND ||
                      phase == lzbf_pkg::PH_SC1 || phase == lzbf_pkg::PH_SC2);

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (cs != lzbf_pkg::CS_IDLE) || !out_free || bits_pend;

  assign hdr_sum_next = header_sum + in_byte;
  assign produced_inc = (produced != PW'(WINDOW_BYTES)) ? produced + 1'b1 : produced;

  lzbf_history #(.AW(AW)) u_hist (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(rdata)
  );

  // Decode the accepted byte into a copy request
  always_comb begin
    logic [15:0] w;
    req = '0;
    w = {in_byte, held_byte};
    if (phase == lzbf_pkg::PH_SOFF) begin
      req.go = 1'b1;
      req.distance = 17'd256 - {9'd0, in_byte};
      req.count = {7'd0, scb} + 9'd2;
    end else if (phase == lzbf_pkg::PH_LHI && w[2:0] != 3'd0) begin
      req.go = 1'b1;
      req.distance = 17'(lzbf_pkg::LONG_SPAN) - {4'd0, w[15:3]};
      req.count = {6'd0, w[2:0]} + 9'd2;
    end else if (phase == lzbf_pkg::PH_LCNT && in_byte != 8'd0) begin
      req.go = 1'b1;
      req.distance = 17'(lzbf_pkg::LONG_SPAN) - {4'd0, size_word[15:3]};
      req.count = {1'b0, in_byte} + 9'd2;
    end
  end

  // Copy step: source byte for the read currently in flight
  logic [7:0] cur_byte;
  logic       step;
  assign cur_byte = rd_early ? 8'd0 : (fwd_use ? fwd_byte : rdata);
  assign step = (cs == lzbf_pkg::CS_COPY) && rd_pend && out_free;

  // Load the result register on a header, literal, end code, full chunk or a copy's last byte
  assign out_load = (in_acc && ((phase == lzbf_pkg::PH_HDR &&
                                 header_index == lzbf_pkg::HDR_LAST) ||
                                phase == lzbf_pkg::PH_LIT ||
                                (phase == lzbf_pkg::PH_LCNT && !req.go))) ||
                    (step && (acc_n == 4'd7 || cnt == 9'd1));

  // Memory ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wp;
    mem_wd = in_byte;
    mem_ra = wp - distance[AW-1:0];
    if (in_acc && phase == lzbf_pkg::PH_LIT) begin
      mem_we = 1'b1;
    end else if (in_acc && req.go) begin
      mem_ra = wp - req.distance[AW-1:0];
    end else if (step) begin
      mem_we = 1'b1;
      mem_wd = cur_byte;
      mem_ra = wp + 1'b1 - distance[AW-1:0];
    end
  end

  // Next control state
  always_comb begin
    cs_next = cs;
    unique case (cs)
      lzbf_pkg::CS_IDLE: if (in_acc && req.go) cs_next = lzbf_pkg::CS_COPY;
      lzbf_pkg::CS_COPY: if (step && cnt == 9'd1) cs_next = lzbf_pkg::CS_EMIT;
      lzbf_pkg::CS_EMIT: if (out_free) cs_next = lzbf_pkg::CS_IDLE;
      default: cs_next = lzbf_pkg::CS_IDLE;
    endcase
  end

  // Next decode phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      lzbf_pkg::PH_HDR:
        if (header_index == lzbf_pkg::HDR_LAST)
          phase_next = (hdr_sum_next == lzbf_pkg::HDR_SUM) ?
                       lzbf_pkg::PH_TOP : lzbf_pkg::PH_BAD;
      lzbf_pkg::PH_LIT, lzbf_pkg::PH_SOFF: phase_next = lzbf_pkg::PH_TOP;
      lzbf_pkg::PH_LLO: phase_next = lzbf_pkg::PH_LHI;
      lzbf_pkg::PH_LHI:
        phase_next = req.go ? lzbf_pkg::PH_TOP : lzbf_pkg::PH_LCNT;
      lzbf_pkg::PH_LCNT:
        phase_next = req.go ? lzbf_pkg::PH_TOP : lzbf_pkg::PH_DONE;
      default: phase_next = phase;
    endcase
  end

  // Bit-level phases consume one control bit per cycle while idle
  logic bit_step;
  assign bit_step = (cs == lzbf_pkg::CS_IDLE) && bits_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= lzbf_pkg::CS_IDLE;
      phase <= lzbf_pkg::PH_HDR;
      header_index <= '0;
      header_sum <= '0;
      size_word <= '0;
      bit_queue <= '0;
      bits_left <= '0;
      held_byte <= '0;
      scb <= '0;
      wp <= '0;
      produced <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      cnt <= '0;
      acc_n <= '0;
      acc_early <= 1'b0;
    end else begin
      cs <= cs_next;
      // Load a new result or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Consume a control bit
      if (bit_step) begin
        bit_queue <= bit_queue >> 1;
        bits_left <= bits_left - 5'd1;
        unique case (phase)
          lzbf_pkg::PH_TOP:
            phase <= bit_queue[0] ? lzbf_pkg::PH_LIT : lzbf_pkg::PH_KIND;
          lzbf_pkg::PH_KIND:
            phase <= bit_queue[0] ? lzbf_pkg::PH_LLO : lzbf_pkg::PH_SC1;
          lzbf_pkg::PH_SC1: begin
            scb <= {bit_queue[0], 1'b0};
            phase <= lzbf_pkg::PH_SC2;
          end
          default: begin
            scb <= {scb[1], bit_queue[0]};
            phase <= lzbf_pkg::PH_SOFF;
          end
        endcase
      end
      // Accept a byte
      if (in_acc) begin
        phase <= phase_next;
        unique case (phase)
          lzbf_pkg::PH_HDR: begin
            header_sum <= hdr_sum_next;
            if (header_index == 3'd0) size_word <= {8'd0, in_byte};
            if (header_index == 3'd1) size_word[15:8] <= in_byte;
            header_index <= (header_index == lzbf_pkg::HDR_LAST) ?
                            3'd0 : header_index + 3'd1;
            if (header_index == lzbf_pkg::HDR_LAST) begin
              out_data <= '0;
              out_count <= '0;
              last <= 1'b1;
              bits_left <= '0;
              if (hdr_sum_next == lzbf_pkg::HDR_SUM) begin
                status <= lzbf_pkg::ST_HDR_OK;
                stream_size <= size_word;
              end else begin
                status <= lzbf_pkg::ST_BAD;
                stream_size <= '0;
              end
            end
          end
          lzbf_pkg::PH_TOP, lzbf_pkg::PH_KIND, lzbf_pkg::PH_SC1,
          lzbf_pkg::PH_SC2: begin
            if (bits_left == 5'd0) begin
              held_byte <= in_byte;
              bits_left <= 5'd17;
            end else begin
              bit_queue <= {in_byte, held_byte};
              bits_left <= 5'd16;
            end
          end
          lzbf_pkg::PH_LIT: begin
            wp <= wp + 1'b1;
            produced <= produced_inc;
            out_data <= {56'd0, in_byte};
            out_count <= 4'd1;
            status <= lzbf_pkg::ST_DATA;
            stream_size <= '0;
            last <= 1'b1;
          end
          lzbf_pkg::PH_LLO: held_byte <= in_byte;
          lzbf_pkg::PH_LHI: size_word <= {in_byte, held_byte};
          lzbf_pkg::PH_LCNT: begin
            if (!req.go) begin
              out_data <= '0;
              out_count <= '0;
              status <= lzbf_pkg::ST_END;
              stream_size <= '0;
              last <= 1'b1;
            end
          end
          default: ;
        endcase
        if (req.go) begin
          cnt <= req.count;
          distance <= req.distance;
          rd_pend <= 1'b1;
          rd_early <= produced < PW'(req.distance);
          fwd_use <= 1'b0;
          acc <= '0;
          acc_n <= '0;
          acc_early <= 1'b0;
        end
      end
      // Copy one byte
      if (step) begin
        wp <= wp + 1'b1;
        produced <= produced_inc;
        cnt <= cnt - 9'd1;
        fwd_use <= (distance == 17'd1);
        fwd_byte <= cur_byte;
        rd_early <= produced_inc < PW'(distance);
        if (acc_n == 4'd7 || cnt == 9'd1) begin
          out_data <= acc | ({56'd0, cur_byte} << (acc_n[2:0] * 8));
          out_count <= acc_n + 4'd1;
          status <= (acc_early || rd_early) ? lzbf_pkg::ST_EARLY : lzbf_pkg::ST_DATA;
          stream_size <= '0;
          last <= (cnt == 9'd1);
          acc <= '0;
          acc_n <= '0;
          acc_early <= 1'b0;
        end else begin
          acc[acc_n[2:0]*8 +: 8] <= cur_byte;
          acc_n <= acc_n + 4'd1;
          acc_early <= acc_early || rd_early;
        end
        if (cnt == 9'd1) rd_pend <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_copy_stalls_in, clk, rst, cs != lzbf_pkg::CS_IDLE, in_stall,
                  "input taken during copy")
  `ASSERT_IMPLIES(a_count_range, clk, rst, out_valid, out_count <= 4'd8,
                  "result count above eight")
  `ASSERT_NEXT(a_copy_ends, clk, rst, step && cnt == 9'd1, cs == lzbf_pkg::CS_EMIT,
               "copy did not finish")

endmodule

// ----- rtl/lzbf_history.sv -----
// ----------------------------------------------------------------------------
// lzbf_history
// History window memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzbf_history #(
  parameter int unsigned AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/lz_bitflag_decompressor_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz_bitflag_decompressor_unit_tb
// Drives one well-formed compressed stream through the decompressor. The
// stream has a valid header, directed tokens at the field extremes, random
// literals and matches, and an end code. A few stray bytes follow the end
// code. Every output chunk is checked against a bit-exact decoder model.
// ----------------------------------------------------------------------------
module lz_bitflag_decompressor_unit_tb;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic [2:0]  st;
    logic [15:0] size;
    logic        last;
  } chunk_t;

  typedef enum int { TK_LIT, TK_SHORT, TK_LONG } token_kind_t;

  typedef struct {
    token_kind_t kind;
    int          scnt;
    int          distance;
    int          lcnt;
    int          extra;
    int          val;
  } token_t;

  // Decoder model and store of expected output chunks
  class decode_scoreboard;
    lzbf_pkg::phase_t phase;
    int          hdr_idx;
    logic [7:0]  hdr_sum;
    logic [15:0] size_word;
    logic [15:0] ctl_bits;
    int          ctl_left;
    logic [7:0]  held;
    logic [1:0]  scnt;
    logic [7:0]  hist [8192];
    int          wptr;
    int          produced;
    chunk_t      batch[$];
    chunk_t      pending_chunks[$];

    function new();
      phase = lzbf_pkg::PH_HDR;
      hdr_idx = 0;
      hdr_sum = '0;
      size_word = '0;
      ctl_bits = '0;
      ctl_left = 0;
      held = '0;
      scnt = '0;
      wptr = 0;
      produced = 0;
    endfunction

    function void add(logic [63:0] d, int n, logic [2:0] s, logic [15:0] sz);
      chunk_t c;
      c.data = d;
      c.count = 4'(n);
      c.st = s;
      c.size = sz;
      c.last = 1'b0;
      batch.push_back(c);
    endfunction

    function void store(logic [7:0] v);
      hist[wptr] = v;
      wptr = (wptr + 1) % 8192;
      if (produced < 8192) produced++;
    endfunction

    function void copy_bytes(int distance, int count);
      logic [63:0] d;
      logic [7:0]  v;
      int          n;
      bit          early;
      d = '0;
      n = 0;
      early = 0;
      while (count > 0) begin
        v = '0;
        if (distance > produced) early = 1;
        else v = hist[(wptr + 8192 - distance) % 8192];
        store(v);
        d |= 64'(v) << (8 * n);
        n++;
        count--;
        if (n == 8 || count == 0) begin
          add(d, n, early ? lzbf_pkg::ST_EARLY : lzbf_pkg::ST_DATA, '0);
          d = '0;
          n = 0;
          early = 0;
        end
      end
    endfunction

    // Work out the chunks caused by one accepted byte
    function void decode_byte(logic [7:0] b);
      logic fb;
      batch.delete();
      case (phase)
        lzbf_pkg::PH_HDR: begin
          hdr_sum += b;
          if (hdr_idx == 0) size_word = {8'h00, b};
          else if (hdr_idx == 1) size_word[15:8] = b;
          hdr_idx++;
          if (hdr_idx >= 6) begin
            hdr_idx = 0;
            if (hdr_sum == lzbf_pkg::HDR_SUM) begin
              add('0, 0, lzbf_pkg::ST_HDR_OK, size_word);
              phase = lzbf_pkg::PH_TOP;
              ctl_left = 0;
            end else begin
              add('0, 0, lzbf_pkg::ST_BAD, '0);
              phase = lzbf_pkg::PH_BAD;
            end
          end
        end
        lzbf_pkg::PH_TOP, lzbf_pkg::PH_KIND, lzbf_pkg::PH_SC1, lzbf_pkg::PH_SC2: begin
          if (ctl_left == 0) begin
            held = b;
            ctl_left = 17;
          end else begin
            ctl_bits = {b, held};
            ctl_left = 16;
          end
        end
        lzbf_pkg::PH_LIT: begin
          store(b);
          add(64'(b), 1, lzbf_pkg::ST_DATA, '0);
          phase = lzbf_pkg::PH_TOP;
        end
        lzbf_pkg::PH_SOFF: begin
          copy_bytes(256 - int'(b), int'(scnt) + 2);
          phase = lzbf_pkg::PH_TOP;
        end
        lzbf_pkg::PH_LLO: begin
          held = b;
          phase = lzbf_pkg::PH_LHI;
        end
        lzbf_pkg::PH_LHI: begin
          size_word = {b, held};
          if (size_word[2:0] != 0) begin
            copy_bytes(8192 - int'(size_word[15:3]), int'(size_word[2:0]) + 2);
            phase = lzbf_pkg::PH_TOP;
          end else begin
            phase = lzbf_pkg::PH_LCNT;
          end
        end
        lzbf_pkg::PH_LCNT: begin
          if (b == 0) begin
            add('0, 0, lzbf_pkg::ST_END, '0);
            phase = lzbf_pkg::PH_DONE;
          end else begin
            copy_bytes(8192 - int'(size_word[15:3]), int'(b) + 2);
            phase = lzbf_pkg::PH_TOP;
          end
        end
        default: ;
      endcase
      // Consume control bits until a byte is needed
      while (phase inside {lzbf_pkg::PH_TOP, lzbf_pkg::PH_KIND,
                           lzbf_pkg::PH_SC1, lzbf_pkg::PH_SC2} &&
             ctl_left >= 1 && ctl_left <= 16) begin
        fb = ctl_bits[0];
        ctl_bits = ctl_bits >> 1;
        ctl_left--;
        case (phase)
          lzbf_pkg::PH_TOP:  phase = fb ? lzbf_pkg::PH_LIT : lzbf_pkg::PH_KIND;
          lzbf_pkg::PH_KIND: phase = fb ? lzbf_pkg::PH_LLO : lzbf_pkg::PH_SC1;
          lzbf_pkg::PH_SC1: begin
            scnt = {fb, 1'b0};
            phase = lzbf_pkg::PH_SC2;
          end
          default: begin
            scnt[0] = fb;
            phase = lzbf_pkg::PH_SOFF;
          end
        endcase
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_chunks.push_back(batch[i]);
    endfunction

    // Compare one output chunk with the oldest expectation
    function string check_chunk(chunk_t got);
      chunk_t exp_c;
      if (pending_chunks.size() == 0)
        return $sformatf("unexpected chunk data=%h count=%0d status=%0d",
                         got.data, got.count, got.st);
      exp_c = pending_chunks.pop_front();
      if (got.data !== exp_c.data || got.count !== exp_c.count ||
          got.st !== exp_c.st || got.size !== exp_c.size || got.last !== exp_c.last)
        return $sformatf("got data=%h cnt=%0d st=%0d size=%h last=%b, want %h %0d %0d %h %b",
                         got.data, got.count, got.st, got.size, got.last,
                         exp_c.data, exp_c.count, exp_c.st, exp_c.size, exp_c.last);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic [2:0]  status;
  logic [15:0] stream_size;
  logic        last;

  decode_scoreboard sb;
  int          mismatches;
  int          rx_stall_pct;
  logic [7:0]  stream_q[$];
  bit          flag_q[$];
  token_t      token_q[$];
  token_t      directed_q[$];
  int          gen_left;
  int          gen_produced;
  bit          finishing;

  lz_bitflag_decompressor_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .out_count(out_count), .status(status), .stream_size(stream_size), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Note accepted bytes and check accepted chunks
  always @(posedge clk) begin
    chunk_t c;
    string  msg;
    if (!rst && in_valid && !in_stall) sb.decode_byte(in_byte);
    if (!rst && out_valid && !out_stall) begin
      c.data = out_data;
      c.count = out_count;
      c.st = status;
      c.size = stream_size;
      c.last = last;
      msg = sb.check_chunk(c);
      if (msg != "") report(msg);
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  function automatic token_t mk(token_kind_t k, int sc, int d, int lc, int ex, int v);
    token_t t;
    t.kind = k;
    t.scnt = sc;
    t.distance = d;
    t.lcnt = lc;
    t.extra = ex;
    t.val = v;
    return t;
  endfunction

  function automatic int pick_dist(int span);
    int lim;
    lim = (gen_produced < span) ? gen_produced : span;
    if (lim > 0 && $urandom_range(0, 9) != 0) return $urandom_range(1, lim);
    return $urandom_range(1, span);
  endfunction

  function automatic token_t random_token();
    int r;
    int ex;
    if (finishing) return mk(TK_LONG, 0, pick_dist(8192), 0, 0, 0);
    r = $urandom_range(0, 9);
    if (r < 4) return mk(TK_LIT, 0, 0, 0, 0, $urandom_range(0, 255));
    if (r < 7) return mk(TK_SHORT, $urandom_range(0, 3), pick_dist(256), 0, 0, 0);
    ex = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 255) : $urandom_range(1, 20);
    return mk(TK_LONG, 0, pick_dist(8192), $urandom_range(0, 7), ex, 0);
  endfunction

  // Queue a token and its control bits
  function automatic void plan_token();
    token_t t;
    t = (directed_q.size() > 0) ? directed_q.pop_front() : random_token();
    token_q.push_back(t);
    case (t.kind)
      TK_LIT: begin
        flag_q.push_back(1'b1);
        gen_produced++;
      end
      TK_SHORT: begin
        flag_q.push_back(1'b0);
        flag_q.push_back(1'b0);
        flag_q.push_back(t.scnt[1]);
        flag_q.push_back(t.scnt[0]);
        gen_produced += t.scnt + 2;
      end
      default: begin
        flag_q.push_back(1'b0);
        flag_q.push_back(1'b1);
        gen_produced += (t.lcnt != 0) ? t.lcnt + 2 : (t.extra != 0 ? t.extra + 2 : 0);
      end
    endcase
  endfunction

  function automatic void take_flag();
    logic [15:0] w;
    if (gen_left == 0) begin
      while (flag_q.size() < 16) plan_token();
      for (int i = 0; i < 16; i++) w[i] = flag_q.pop_front();
      stream_q.push_back(w[7:0]);
      stream_q.push_back(w[15:8]);
      gen_left = 16;
    end
    gen_left--;
  endfunction

  // Emit one token; returns 1 on the end code
  function automatic bit emit_token();
    token_t      t;
    logic [15:0] w;
    if (token_q.size() == 0) plan_token();
    t = token_q.pop_front();
    case (t.kind)
      TK_LIT: begin
        take_flag();
        stream_q.push_back(8'(t.val));
      end
      TK_SHORT: begin
        repeat (4) take_flag();
        stream_q.push_back(8'(256 - t.distance));
      end
      default: begin
        repeat (2) take_flag();
        w = {13'(8192 - t.distance), 3'(t.lcnt)};
        stream_q.push_back(w[7:0]);
        stream_q.push_back(w[15:8]);
        if (t.lcnt == 0) begin
          stream_q.push_back(8'(t.extra));
          if (t.extra == 0) return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void build_stream();
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    for (int i = 0; i < 5; i++) begin
      b = 8'($urandom_range(0, 255));
      stream_q.push_back(b);
      sum += b;
    end
    stream_q.push_back(lzbf_pkg::HDR_SUM - sum);
    // Directed tokens: early references, extremes of counts and distances
    directed_q.push_back(mk(TK_SHORT, 0, 256, 0, 0, 0));
    directed_q.push_back(mk(TK_LIT, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(TK_LIT, 0, 0, 0, 0, 255));
    directed_q.push_back(mk(TK_SHORT, 3, 1, 0, 0, 0));
    directed_q.push_back(mk(TK_SHORT, 1, 2, 0, 0, 0));
    directed_q.push_back(mk(TK_LONG, 0, 8192, 7, 0, 0));
    directed_q.push_back(mk(TK_LONG, 0, 1, 1, 0, 0));
    directed_q.push_back(mk(TK_LONG, 0, 3, 0, 1, 0));
    directed_q.push_back(mk(TK_LONG, 0, 5, 0, 255, 0));
    directed_q.push_back(mk(TK_SHORT, 2, 4, 0, 0, 0));
    while (stream_q.size() < 410) void'(emit_token());
    finishing = 1;
    while (!emit_token()) ;
    // Stray bytes after the end code are ignored
    repeat (4) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Present one byte and hold it until taken
  task automatic send_byte(logic [7:0] b, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int total;
    int quarter;
    int idle_pct;
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = '0;
    out_stall = 1'b0;
    rx_stall_pct = 0;
    mismatches = 0;
    gen_left = 0;
    gen_produced = 0;
    finishing = 0;
    sb = new();
    build_stream();
    total = stream_q.size();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < total; i++) begin
      quarter = (i * 4) / total;
      case (quarter)
        0: begin idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin idle_pct = 83; rx_stall_pct = 0;  end
        2: begin idle_pct = 0;  rx_stall_pct = 83; end
        default: begin idle_pct = 30; rx_stall_pct = 30; end
      endcase
      // Hold off until the block has drained once
      if (i == total / 2) begin
        in_valid = 1'b0;
        while (sb.pending_chunks.size() != 0) @(negedge clk);
      end
      send_byte(stream_q[i], idle_pct);
    end
    in_valid = 1'b0;
    waited = 0;
    while (sb.pending_chunks.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (mismatches == 0 && sb.pending_chunks.size() == 0) begin
      $display("lz_bitflag_decompressor_unit_tb: clean");
    end else begin
      if (sb.pending_chunks.size() != 0)
        report($sformatf("%0d chunks never arrived", sb.pending_chunks.size()));
      $display("lz_bitflag_decompressor_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("lz_bitflag_decompressor_unit_tb: errors");
    $finish;
  end

endmodule

// ----- lz_bitflag_decompressor_unit.f -----
+incdir+rtl
rtl/lzbf_pkg.sv
rtl/lzbf_history.sv
rtl/lz_bitflag_decompressor_unit.sv
tb/sv/lz_bitflag_decompressor_unit_tb.sv
